// ===== src/afr_pkg.sv =====
// afr_pkg: shared types and constants of the addressed frame receiver
// no dependencies; imported by afr_core, afr_skid and the top level
`default_nettype none

package afr_pkg;

  localparam int unsigned MaxParamsDefault = 15;
  localparam int unsigned IdleSyncReset    = 16;

  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] CFG_STATION_ADDRESS = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_IDLE_TICKS      = 1'b1;

  localparam logic [7:0] CMD_READ_INPUTS  = 8'd9;
  localparam logic [7:0] CMD_WRITE_OUTPUT = 8'd10;
  localparam logic [7:0] CMD_READ_STATUS  = 8'd11;
  localparam logic [7:0] CMD_EXT_READ     = 8'd158;
  localparam logic [7:0] CMD_EXT_WRITE    = 8'd159;

  localparam logic [7:0] SRC_LOW  = 8'd34;
  localparam logic [7:0] SRC_HIGH = 8'd41;

  typedef enum logic [2:0] {
    ST_NONE   = 3'd0,
    ST_OURS   = 3'd1,
    ST_OTHER  = 3'd2,
    ST_CSUM   = 3'd3,
    ST_LEN    = 3'd4,
    ST_REJECT = 3'd5,
    ST_LINE   = 3'd6
  } afr_status_e;

  typedef struct packed {
    afr_status_e status;
    logic [7:0]  dst_address;
    logic [7:0]  src_address;
    logic [7:0]  command_code;
    logic [3:0]  param_count;
    logic [7:0]  first_param;
  } afr_result_t;

endpackage

`default_nettype wire

// ===== src/afr_core.sv =====
// afr_core: sync tracking, frame parsing and checksum state of the receiver
// depends on afr_pkg; result is combinational and captured by afr_skid
`default_nettype none

module afr_core import afr_pkg::*; #(
  parameter int unsigned MaxParams = MaxParamsDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  input  wire logic        accept_i,
  input  wire logic        mode_i,
  input  wire logic [7:0]  rx_byte_i,
  input  wire logic        framing_error_i,
  input  wire logic        overrun_error_i,
  output afr_result_t      result_o
);

  localparam int unsigned PosW = $clog2(MaxParams + 5);
  localparam int unsigned CntW = $clog2(MaxParams + 1);
  localparam logic [7:0]  MaxCnt = 8'(MaxParams);

  logic [5:0]      station_q, station_d;
  logic [15:0]     thresh_q, thresh_d;
  logic            synced_q, synced_d;
  logic [15:0]     idle_q, idle_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [7:0]      sum_q, sum_d;
  logic [7:0]      dst_q, dst_d;
  logic [7:0]      src_q, src_d;
  logic [7:0]      cmd_q, cmd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [7:0]      par_q, par_d;

  logic [16:0]     idle_inc;
  logic [PosW-1:0] csum_pos;
  logic [7:0]      cnt_ext;
  logic            cmd_ok, src_ok;

  assign idle_inc = {1'b0, idle_q} + 17'd1;
  assign csum_pos = PosW'(cnt_q) + PosW'(4);
  assign cnt_ext  = 8'(cnt_q);
  assign cmd_ok   = cmd_q inside {CMD_READ_INPUTS, CMD_WRITE_OUTPUT, CMD_READ_STATUS,
                                  CMD_EXT_READ, CMD_EXT_WRITE};
  assign src_ok   = src_q inside {[SRC_LOW:SRC_HIGH]};

  always_comb begin
    station_d = station_q;
    thresh_d  = thresh_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_STATION_ADDRESS: station_d = cfg_data_i[5:0];
        CFG_IDLE_TICKS:      thresh_d  = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    synced_d = synced_q;
    idle_d   = idle_q;
    pos_d    = pos_q;
    sum_d    = sum_q;
    dst_d    = dst_q;
    src_d    = src_q;
    cmd_d    = cmd_q;
    cnt_d    = cnt_q;
    par_d    = par_q;
    result_o = '{status: ST_NONE, default: '0};

    if (mode_i) begin
      if (idle_inc >= {1'b0, thresh_q}) begin
        synced_d = 1'b1;
        idle_d   = '0;
      end else begin
        idle_d = idle_inc[15:0];
      end
    end else begin
      idle_d = '0;
      if (framing_error_i || overrun_error_i) begin
        result_o.status = ST_LINE;
        synced_d = 1'b0;
        pos_d = '0; sum_d = '0;
        dst_d = '0; src_d = '0; cmd_d = '0; cnt_d = '0; par_d = '0;
      end else if (synced_q) begin
        if (pos_q == PosW'(3)) begin
          if (rx_byte_i > MaxCnt) begin
            result_o.status = ST_LEN;
            synced_d = 1'b0;
            pos_d = '0; sum_d = '0;
            dst_d = '0; src_d = '0; cmd_d = '0; cnt_d = '0; par_d = '0;
          end else begin
            cnt_d = rx_byte_i[CntW-1:0];
            sum_d = sum_q + rx_byte_i;
            pos_d = pos_q + PosW'(1);
          end
        end else if (pos_q > PosW'(3) && pos_q == csum_pos) begin
          // checksum byte closes the frame
          pos_d = '0; sum_d = '0;
          dst_d = '0; src_d = '0; cmd_d = '0; cnt_d = '0; par_d = '0;
          if (rx_byte_i != sum_q) begin
            result_o.status = ST_CSUM;
            synced_d = 1'b0;
          end else begin
            result_o.dst_address  = dst_q;
            result_o.src_address  = src_q;
            result_o.command_code = cmd_q;
            result_o.param_count  = cnt_ext[3:0];
            result_o.first_param  = (cnt_q != '0) ? par_q : 8'd0;
            if (dst_q != {2'b00, station_q}) begin
              result_o.status = ST_OTHER;
            end else if (cmd_ok && src_ok) begin
              result_o.status = ST_OURS;
            end else begin
              result_o.status = ST_REJECT;
              synced_d = 1'b0;
            end
          end
        end else begin
          case (pos_q)
            PosW'(0): dst_d = rx_byte_i;
            PosW'(1): src_d = rx_byte_i;
            PosW'(2): cmd_d = rx_byte_i;
            PosW'(4): par_d = rx_byte_i;
            default: ;
          endcase
          sum_d = sum_q + rx_byte_i;
          pos_d = pos_q + PosW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      station_q <= '0;
      thresh_q  <= 16'(IdleSyncReset);
    end else begin
      station_q <= station_d;
      thresh_q  <= thresh_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      synced_q <= 1'b0;
      idle_q   <= '0;
      pos_q    <= '0;
      sum_q    <= '0;
      dst_q    <= '0;
      src_q    <= '0;
      cmd_q    <= '0;
      cnt_q    <= '0;
      par_q    <= '0;
    end else if (accept_i) begin
      synced_q <= synced_d;
      idle_q   <= idle_d;
      pos_q    <= pos_d;
      sum_q    <= sum_d;
      dst_q    <= dst_d;
      src_q    <= src_d;
      cmd_q    <= cmd_d;
      cnt_q    <= cnt_d;
      par_q    <= par_d;
    end
  end

endmodule

`default_nettype wire

// ===== src/afr_skid.sv =====
// afr_skid: result register plus skid slot between the core and the output
// depends on afr_pkg for the result struct
`default_nettype none

module afr_skid import afr_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  input  wire afr_result_t  data_i,
  output logic              full_o,
  output logic              valid_o,
  input  wire logic         stall_i,
  output afr_result_t       data_o
);

  logic        main_valid_q, skid_valid_q;
  afr_result_t main_q, skid_q;
  logic        pop;

  assign pop     = main_valid_q && !stall_i;
  assign full_o  = skid_valid_q;
  assign valid_o = main_valid_q;
  assign data_o  = main_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (pop) begin
      if (skid_valid_q) begin
        skid_valid_q <= 1'b0;
      end else begin
        main_valid_q <= push_i;
      end
    end else if (push_i) begin
      // no pop: a busy, stalled main parks the request in the skid slot, an empty main takes it
      if (main_valid_q) begin
        skid_valid_q <= 1'b1;
      end else begin
        main_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      if (skid_valid_q) begin
        main_q <= skid_q;
      end else if (push_i) begin
        main_q <= data_i;
      end
    end else if (push_i) begin
      if (main_valid_q) begin
        skid_q <= data_i;
      end else begin
        main_q <= data_i;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/addressed_frame_receiver_unit.sv =====
// addressed_frame_receiver_unit: top level of the bus-station frame receiver
// depends on afr_pkg, afr_core and afr_skid
//
//   channel  direction  handshake                  payload
//   in       to block   in_valid_i / in_stall_o    mode, rx_byte, framing/overrun error
//   out      from block out_valid_o / out_stall_i  status and completed frame fields
//   cfg      to block   cfg_we_i                   cfg_index_i, cfg_data_i
//
// one request per cycle unless stalled; each result is registered in the output stage
// the per-byte work is a compare and an 8-bit add between the state and result registers
// rst_ni clears sync, idle count, frame state and the output stage; config returns to reset
// a stalled output fills the skid slot, after which in_stall_o is raised
`default_nettype none

module addressed_frame_receiver_unit import afr_pkg::*; #(
  parameter int unsigned MaxParams = MaxParamsDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        mode_i,
  input  wire logic [7:0]  rx_byte_i,
  input  wire logic        framing_error_i,
  input  wire logic        overrun_error_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [2:0]       status_o,
  output logic [7:0]       dst_address_o,
  output logic [7:0]       src_address_o,
  output logic [7:0]       command_code_o,
  output logic [3:0]       param_count_o,
  output logic [7:0]       first_param_o
);

  logic        accept;
  logic        full;
  afr_result_t core_res, out_res;

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  afr_core #(
    .MaxParams(MaxParams)
  ) u_core (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_index_i,
    .cfg_data_i,
    .accept_i (accept),
    .mode_i,
    .rx_byte_i,
    .framing_error_i,
    .overrun_error_i,
    .result_o (core_res)
  );

  afr_skid u_skid (
    .clk_i,
    .rst_ni,
    .push_i  (accept),
    .data_i  (core_res),
    .full_o  (full),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .data_o  (out_res)
  );

  assign status_o       = out_res.status;
  assign dst_address_o  = out_res.dst_address;
  assign src_address_o  = out_res.src_address;
  assign command_code_o = out_res.command_code;
  assign param_count_o  = out_res.param_count;
  assign first_param_o  = out_res.first_param;

endmodule

`default_nettype wire

// ===== tb/afr_frame_checker.sv =====
// afr_frame_checker: watches the request, result and register ports of the frame receiver
// predicts each result from its own copy of the receiver state; depends on afr_pkg
module afr_frame_checker import afr_pkg::*; #(
  parameter int unsigned MaxParams = MaxParamsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  logic                mode_i,
  input  logic [7:0]          rx_byte_i,
  input  logic                framing_error_i,
  input  logic                overrun_error_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  logic [2:0]          status_i,
  input  logic [7:0]          dst_address_i,
  input  logic [7:0]          src_address_i,
  input  logic [7:0]          command_code_i,
  input  logic [3:0]          param_count_i,
  input  logic [7:0]          first_param_i,
  output int                  failures_o,
  output int                  pending_o
);

  logic [5:0]  own_address;
  logic [15:0] sync_ticks;

  logic        rx_synced;
  logic [15:0] tick_count;
  logic [4:0]  frame_pos;
  logic [7:0]  frame_sum;
  logic [7:0]  frame_hdr [5];

  afr_result_t frame_reports_due [$];
  int          fail_count;

  function automatic void restart_frame();
    frame_pos = '0;
    frame_sum = '0;
    for (int i = 0; i < 5; i++) frame_hdr[i] = '0;
  endfunction

  function automatic void drop_sync();
    restart_frame();
    rx_synced  = 1'b0;
    tick_count = '0;
  endfunction

  function automatic afr_result_t advance_receiver(logic mode, logic [7:0] b, logic fe,
                                                   logic oe);
    afr_result_t r;
    logic [16:0] next_ticks;
    logic [4:0]  pos;
    logic [7:0]  cnt;
    logic        cmd_ok;
    logic        src_ok;
    r = '0;
    if (mode) begin
      next_ticks = {1'b0, tick_count} + 17'd1;
      if (next_ticks >= {1'b0, sync_ticks}) begin
        rx_synced  = 1'b1;
        tick_count = '0;
      end else begin
        tick_count = next_ticks[15:0];
      end
    end else begin
      tick_count = '0;
      if (fe || oe) begin
        drop_sync();
        r.status = ST_LINE;
      end else if (rx_synced) begin
        pos = frame_pos;
        cnt = frame_hdr[3];
        if (pos == 5'd3) begin
          frame_hdr[3] = b;
          if (b > MaxParams) begin
            drop_sync();
            r.status = ST_LEN;
          end else begin
            frame_sum = frame_sum + b;
            frame_pos = pos + 5'd1;
          end
        end else if (pos > 5'd3 && int'(pos) == int'(cnt) + 4) begin
          if (b != frame_sum) begin
            drop_sync();
            r.status = ST_CSUM;
          end else begin
            r.dst_address  = frame_hdr[0];
            r.src_address  = frame_hdr[1];
            r.command_code = frame_hdr[2];
            r.param_count  = cnt[3:0];
            r.first_param  = (cnt != 8'd0) ? frame_hdr[4] : 8'd0;
            cmd_ok = frame_hdr[2] inside {CMD_READ_INPUTS, CMD_WRITE_OUTPUT, CMD_READ_STATUS,
                                          CMD_EXT_READ, CMD_EXT_WRITE};
            src_ok = frame_hdr[1] >= SRC_LOW && frame_hdr[1] <= SRC_HIGH;
            // destination is a full byte, the strap address only six bits
            if (frame_hdr[0] != {2'b00, own_address}) begin
              r.status = ST_OTHER;
              restart_frame();
            end else if (cmd_ok && src_ok) begin
              r.status = ST_OURS;
              restart_frame();
            end else begin
              r.status = ST_REJECT;
              drop_sync();
            end
          end
        end else begin
          if (pos < 5'd5) frame_hdr[pos] = b;
          frame_sum = frame_sum + b;
          frame_pos = pos + 5'd1;
        end
      end
    end
    return r;
  endfunction

  function automatic void compare_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    afr_result_t want;
    if (!rst_ni) begin
      own_address = '0;
      sync_ticks  = 16'(IdleSyncReset);
      drop_sync();
      frame_reports_due.delete();
      fail_count  = 0;
      failures_o <= 0;
      pending_o  <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (frame_reports_due.size() == 0) begin
          $display("%0t: unexpected result, expected none actual status %0d", $time, status_i);
          fail_count++;
        end else begin
          want = frame_reports_due.pop_front();
          compare_field("status", want.status, status_i);
          compare_field("dst_address", want.dst_address, dst_address_i);
          compare_field("src_address", want.src_address, src_address_i);
          compare_field("command_code", want.command_code, command_code_i);
          compare_field("param_count", want.param_count, param_count_i);
          compare_field("first_param", want.first_param, first_param_i);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        frame_reports_due.push_back(advance_receiver(mode_i, rx_byte_i, framing_error_i,
                                                     overrun_error_i));
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_STATION_ADDRESS: own_address = cfg_data_i[5:0];
          CFG_IDLE_TICKS:      sync_ticks  = cfg_data_i;
          default: ;
        endcase
      end
      failures_o <= fail_count;
      pending_o  <= frame_reports_due.size();
    end
  end

endmodule

// ===== tb/tb_top.sv =====
// tb_top: request generator and verdict for addressed_frame_receiver_unit
// depends on afr_pkg, the receiver RTL and afr_frame_checker
module tb_top;
  import afr_pkg::*;

  localparam int unsigned RandomItems = 1600;
  localparam int unsigned PhaseItems  = 200;
  localparam int unsigned StallLimit  = 2000;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;
  logic                in_valid;
  logic                in_stall;
  logic                mode;
  logic [7:0]          rx_byte;
  logic                framing_error;
  logic                overrun_error;
  logic                out_valid;
  logic                out_stall;
  logic [2:0]          status;
  logic [7:0]          dst_address;
  logic [7:0]          src_address;
  logic [7:0]          command_code;
  logic [3:0]          param_count;
  logic [7:0]          first_param;

  int failures;
  int pending;
  int gap_pct;
  int stall_pct;
  int tick_pct;
  int items_sent;
  int quiet_cycles;
  logic [5:0]  station;
  int unsigned ticks_to_sync;

  addressed_frame_receiver_unit DUT (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .mode_i          (mode),
    .rx_byte_i       (rx_byte),
    .framing_error_i (framing_error),
    .overrun_error_i (overrun_error),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .status_o        (status),
    .dst_address_o   (dst_address),
    .src_address_o   (src_address),
    .command_code_o  (command_code),
    .param_count_o   (param_count),
    .first_param_o   (first_param)
  );

  afr_frame_checker checker_i (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .mode_i          (mode),
    .rx_byte_i       (rx_byte),
    .framing_error_i (framing_error),
    .overrun_error_i (overrun_error),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .status_i        (status),
    .dst_address_i   (dst_address),
    .src_address_i   (src_address),
    .command_code_i  (command_code),
    .param_count_i   (param_count),
    .first_param_i   (first_param),
    .failures_o      (failures),
    .pending_o       (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // watchdog: cycles with no request or result moving
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= StallLimit) begin
        $display("addressed_frame_receiver_unit test failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic send_item(input logic m, input logic [7:0] b, input logic fe, input logic oe);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    mode          <= m;
    rx_byte       <= b;
    framing_error <= fe;
    overrun_error <= oe;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    // stray idle ticks inside a frame must not disturb it
    if ($urandom_range(99) < tick_pct) send_item(1'b1, 8'($urandom_range(255)), 1'b0, 1'b0);
    send_item(1'b0, b, 1'b0, 1'b0);
  endtask

  task automatic send_ticks(input int unsigned n);
    // byte, framing and overrun inputs are don't-care on a tick
    repeat (n) send_item(1'b1, 8'($urandom_range(255)), 1'($urandom_range(1)),
                         1'($urandom_range(1)));
  endtask

  task automatic send_line_error();
    logic [1:0] flags;
    flags = 2'($urandom_range(1, 3));
    send_item(1'b0, 8'($urandom_range(255)), flags[0], flags[1]);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input logic [15:0] addr_word, input logic [15:0] ticks);
    drain();
    write_reg(CFG_STATION_ADDRESS, addr_word);
    write_reg(CFG_IDLE_TICKS, ticks);
    station       = addr_word[5:0];
    ticks_to_sync = (ticks == 16'd0) ? 1 : ticks;
  endtask

  task automatic send_frame(input logic [7:0] dst, input logic [7:0] src, input logic [7:0] cmd,
                            input logic [3:0] cnt, input logic [7:0] first, input bit bad_sum);
    logic [7:0] sum;
    logic [7:0] pb;
    sum = dst + src + cmd + {4'd0, cnt};
    send_byte(dst);
    send_byte(src);
    send_byte(cmd);
    send_byte({4'd0, cnt});
    for (int i = 0; i < cnt; i++) begin
      pb = (i == 0) ? first : 8'($urandom_range(255));
      send_byte(pb);
      sum = sum + pb;
    end
    send_byte(bad_sum ? sum ^ 8'($urandom_range(1, 255)) : sum);
  endtask

  task automatic send_random_frame();
    logic [7:0] dst;
    logic [7:0] src;
    logic [7:0] cmd;
    logic [3:0] cnt;
    int pick;
    pick = $urandom_range(9);
    if (pick < 5) dst = {2'b00, station};
    else if (pick == 5) dst = {2'($urandom_range(1, 3)), station};
    else dst = 8'($urandom_range(255));
    src = ($urandom_range(3) != 0) ? 8'($urandom_range(34, 41)) : 8'($urandom_range(255));
    case ($urandom_range(6))
      0:       cmd = CMD_READ_INPUTS;
      1:       cmd = CMD_WRITE_OUTPUT;
      2:       cmd = CMD_READ_STATUS;
      3:       cmd = CMD_EXT_READ;
      4:       cmd = CMD_EXT_WRITE;
      default: cmd = 8'($urandom_range(255));
    endcase
    cnt = ($urandom_range(4) != 0) ? 4'($urandom_range(4)) : 4'($urandom_range(5, 15));
    send_frame(dst, src, cmd, cnt, 8'($urandom_range(255)), $urandom_range(9) == 0);
  endtask

  task automatic send_random_sequence();
    int kind;
    kind = $urandom_range(99);
    if (kind < 70) begin
      if ($urandom_range(3) != 0) send_ticks(ticks_to_sync);
      send_random_frame();
    end else if (kind < 78) begin
      // frame cut short by a line error
      send_ticks(ticks_to_sync);
      repeat ($urandom_range(5)) send_byte(8'($urandom_range(255)));
      send_line_error();
    end else if (kind < 86) begin
      send_ticks(ticks_to_sync);
      send_byte(8'($urandom_range(255)));
      send_byte(8'($urandom_range(255)));
      send_byte(8'($urandom_range(255)));
      send_byte(($urandom_range(3) == 0) ? 8'd16 : 8'($urandom_range(16, 255)));
    end else begin
      // noise, then a line error so the next frame starts aligned
      repeat ($urandom_range(1, 8)) begin
        send_item(1'($urandom_range(1)), 8'($urandom_range(255)), $urandom_range(9) == 0,
                  $urandom_range(9) == 0);
      end
      send_line_error();
    end
  endtask

  initial begin
    int phase_start;
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    in_valid      = 1'b0;
    mode          = 1'b0;
    rx_byte       = '0;
    framing_error = 1'b0;
    overrun_error = 1'b0;
    out_stall     = 1'b0;
    gap_pct       = 0;
    stall_pct     = 0;
    tick_pct      = 0;
    items_sent    = 0;
    quiet_cycles  = 0;
    station       = '0;
    ticks_to_sync = IdleSyncReset;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset registers first, bytes dropped until synchronised
    send_byte(8'h00);
    send_item(1'b0, 8'hFF, 1'b1, 1'b0);
    send_item(1'b0, 8'h5A, 1'b0, 1'b1);
    send_item(1'b0, 8'hA5, 1'b1, 1'b1);
    send_ticks(IdleSyncReset);
    send_frame(8'd0, SRC_LOW, CMD_READ_INPUTS, 4'd1, 8'hFF, 1'b0);
    send_line_error();
    // largest threshold, then lowered under the count already built up
    configure(16'h003F, 16'hFFFF);
    send_ticks(3);
    configure(16'h003F, 16'd2);
    send_ticks(1);
    send_frame(8'd63, SRC_HIGH, CMD_EXT_WRITE, 4'd0, 8'h00, 1'b0);
    send_frame(8'd127, 8'd40, CMD_WRITE_OUTPUT, 4'd2, 8'h00, 1'b0);
    send_frame(8'd63, 8'd33, CMD_READ_STATUS, 4'd0, 8'h00, 1'b0);
    send_ticks(2);
    send_frame(8'd63, SRC_LOW, 8'd12, 4'd0, 8'h00, 1'b0);
    send_ticks(2);
    send_byte(8'd63);
    send_byte(SRC_LOW);
    send_byte(CMD_EXT_READ);
    send_byte(8'd16);
    send_ticks(2);
    send_frame(8'd63, SRC_LOW, CMD_EXT_READ, 4'd0, 8'h00, 1'b1);

    tick_pct = 4;
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0:       configure(16'h0000, 16'd1);
        1:       configure(16'h003F, 16'd2);
        2:       configure(16'hFFC0 | 16'($urandom_range(63)), 16'd0);
        3:       configure(16'($urandom_range(63)), 16'd3);
        4:       configure(16'($urandom_range(63)), 16'd1);
        5:       configure(16'h003F, 16'd16);
        6:       configure(16'($urandom_range(63)), 16'd4);
        default: configure(16'h0000, 16'd2);
      endcase
      case (phase % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 47; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 47; end
        default: begin gap_pct = 22; stall_pct = 22; end
      endcase
      phase_start = items_sent;
      while (items_sent < phase_start + int'(RandomItems / 8)) send_random_sequence();
    end

    drain();
    repeat (3) @(posedge clk);
    if (failures == 0) begin
      $display("addressed_frame_receiver_unit test passed");
    end else begin
      $display("addressed_frame_receiver_unit test failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/afr_pkg.sv
src/afr_core.sv
src/afr_skid.sv
src/addressed_frame_receiver_unit.sv
tb/afr_frame_checker.sv
tb/tb_top.sv
